// ===== hw/rtl/nlc_pkg.sv =====
// Shared constants, codes and constant tables of the NTT linear convolution unit.
package nlc_pkg;

   // Store depth follows from the transform size limit.
   localparam int LOG_SIZE = 11;
   localparam int DEPTH    = 2 ** LOG_SIZE;
   localparam int ADDR_W   = LOG_SIZE;
   localparam int CNT_W    = LOG_SIZE - 1;
   localparam int LOG_W    = $clog2(LOG_SIZE + 1);
   localparam int MAX_COUNT = 2 ** CNT_W - 1;

   // Field widths of the request and response.
   localparam int ACT_W   = 3;
   localparam int SMP_W   = 16;
   localparam int IDX_W   = 11;
   localparam int VALUE_W = 16;
   localparam int LEN_W   = 11;
   localparam int STAT_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   // Field arithmetic.
   localparam int unsigned MODULUS  = 40961;
   localparam int unsigned ROOT     = 243;
   localparam int          ROOT_LOG = 13;
   localparam int unsigned ROOT_ORDER = 2 ** ROOT_LOG;
   localparam longint unsigned MU_WIDE = (64'd1 << 32) / MODULUS;
   localparam logic [16:0] MU = 17'(MU_WIDE);

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR    = 3'd0,
      ACT_LOAD_SIG = 3'd1,
      ACT_LOAD_KER = 3'd2,
      ACT_COMPUTE  = 3'd3,
      ACT_READ     = 3'd4
   } action_type;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

   typedef logic [ROOT_LOG:0][15:0] root_tab_type;
   typedef logic [LOG_SIZE:0][15:0] ninv_tab_type;

   function automatic logic [15:0] mulmod_c(input longint unsigned a, input longint unsigned b);
      return 16'((a * b) % MODULUS);
   endfunction

   function automatic logic [15:0] powmod_c(input longint unsigned base, input int unsigned e);
      longint unsigned r;
      longint unsigned bb;
      int unsigned ee;
      r  = 1;
      bb = base % MODULUS;
      ee = e;
      for (int i = 0; i < 32; i++) begin
         if (ee[0]) r = mulmod_c(r, bb);
         bb = mulmod_c(bb, bb);
         ee = ee >> 1;
      end
      return 16'(r);
   endfunction

   // Entry s holds the root of order 2^s, or its inverse.
   function automatic root_tab_type build_roots(input logic inverse);
      root_tab_type t;
      for (int s = 0; s <= ROOT_LOG; s++) begin
         if (inverse)
            t[s] = powmod_c(ROOT, (ROOT_ORDER - (ROOT_ORDER >> s)) % ROOT_ORDER);
         else
            t[s] = powmod_c(ROOT, ROOT_ORDER >> s);
      end
      return t;
   endfunction

   // Entry l holds the inverse of 2^l.
   function automatic ninv_tab_type build_ninv();
      ninv_tab_type t;
      for (int l = 0; l <= LOG_SIZE; l++) begin
         t[l] = powmod_c(64'd1 << l, MODULUS - 2);
      end
      return t;
   endfunction

   localparam root_tab_type FWD_ROOT = build_roots(1'b0);
   localparam root_tab_type INV_ROOT = build_roots(1'b1);
   localparam ninv_tab_type N_INV    = build_ninv();

endpackage

// ===== hw/rtl/nlc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module nlc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/nlc_modmul.sv =====
// Four-stage pipelined multiplier modulo 40961 using Barrett reduction.
module nlc_modmul import nlc_pkg::*; (
   input  logic        clock,
   input  logic [15:0] op_a,
   input  logic [15:0] op_b,
   output logic [15:0] result
);

   localparam logic [17:0] P1 = 18'(MODULUS);
   localparam logic [17:0] P2 = 18'(2 * MODULUS);

   logic [31:0] prod_ff;
   logic [31:0] prod2_ff;
   logic [15:0] quot_ff;
   logic [17:0] rem_ff;
   logic [15:0] out_ff;
   logic [48:0] wide;
   logic [17:0] rem_in;
   logic [15:0] out_in;

   always_comb begin
      wide   = 49'(prod_ff) * 49'(MU);
      rem_in = 18'(prod2_ff - 32'(quot_ff) * 32'(MODULUS));
      if (rem_ff >= P2)      out_in = 16'(rem_ff - P2);
      else if (rem_ff >= P1) out_in = 16'(rem_ff - P1);
      else                   out_in = 16'(rem_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= 32'(op_a) * 32'(op_b);
      quot_ff  <= 16'(wide >> 32);
      prod2_ff <= prod_ff;
      rem_ff   <= rem_in;
      out_ff   <= out_in;
   end

   assign result = out_ff;

endmodule

// ===== hw/rtl/ntt_linear_convolution_unit.sv =====
// Top level of the NTT linear convolution unit.
// Requests carry an action in req_tuser: clear, load a signal sample, load a kernel sample,
// compute, or read a result; every request answers with exactly one response. Loads, clears
// and the empty case of compute are answered from the idle state; an in-range read goes
// through the registered port of the product memory. A compute of N points (N being twice
// the smallest power of two above the longer sequence) copies both sequences into two work
// memories, runs two forward decimation-in-frequency transforms and one inverse
// decimation-in-time transform of (N/2)*log2(N) butterflies each, multiplies pointwise and
// scales by the inverse of N. The butterfly cost is set by the single read port of the work
// memory and the four-stage modular multiplier that serves both the data product and the
// twiddle update. No request is taken while a response waits. Results remain readable
// until the next compute or clear; the memories need no clearing pass, since counts bound
// every read.
module ntt_linear_convolution_unit import nlc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample [15:0], read_index [26:16]
   input  logic [ACT_W-1:0]      req_tuser,   // action [2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // value [15:0], result_length [26:16]
   output logic [STAT_W-1:0]     rsp_tuser    // status [1:0]
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_COPY  = 7'b0000100,
      ST_FWD   = 7'b0001000,
      ST_POINT = 7'b0010000,
      ST_INV   = 7'b0100000,
      ST_SCALE = 7'b1000000
   } state_type;

   // Micro-steps of one butterfly and of one element pass.
   localparam logic [3:0] US_RD_A   = 4'd0;
   localparam logic [3:0] US_GET_U  = 4'd1;
   localparam logic [3:0] US_GET_T  = 4'd2;
   localparam logic [3:0] US_MUL_D  = 4'd3;
   localparam logic [3:0] US_MUL_X  = 4'd4;
   localparam logic [3:0] US_WR_A   = 4'd7;
   localparam logic [3:0] US_WR_B   = 4'd8;
   localparam logic [3:0] US_E_MUL  = 4'd1;
   localparam logic [3:0] US_E_WR   = 4'd5;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  sig_cnt_ff, sig_cnt_in;
   logic [CNT_W-1:0]  ker_cnt_ff, ker_cnt_in;
   logic [ADDR_W-1:0] valid_ff, valid_in;
   logic [LOG_W-1:0]  log_n_ff, log_n_in;
   logic [LOG_W-1:0]  stage_ff, stage_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [3:0]        us_ff, us_in;
   logic              mem_b_ff, mem_b_in;
   logic [15:0]       x_ff, x_in;
   logic [15:0]       u_ff, u_in;
   logic [15:0]       t_ff, t_in;
   logic [15:0]       res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic              req_fire;
   action_type        act;
   logic [SMP_W-1:0]  req_sample;
   logic [IDX_W-1:0]  req_index;
   logic [15:0]       sample_red;

   logic              sig_we, ker_we, a_we, b_we;
   logic [ADDR_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr, sk_raddr;
   logic [15:0]       a_wdata, b_wdata, sig_rd, ker_rd, a_rd, b_rd;
   logic [15:0]       mul_a, mul_b, mres;

   logic [ADDR_W:0]   n_full;
   logic [ADDR_W-1:0] n_mask, half_last, hbit, hmask, ia, ib;
   logic [15:0]       work_rd, wl, bf_wr;
   logic [CNT_W-1:0]  longer;
   logic [LOG_W-1:0]  new_log;
   logic              idx_last, bf_last;

   function automatic logic [15:0] add_mod(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = 17'(a) + 17'(b);
      return (s >= 17'(MODULUS)) ? 16'(s - 17'(MODULUS)) : 16'(s);
   endfunction

   function automatic logic [15:0] sub_mod(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] d;
      d = (a >= b) ? 17'(a) - 17'(b) : 17'(a) + 17'(MODULUS) - 17'(b);
      return 16'(d);
   endfunction

   nlc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_sig_ram (
      .clock(clock), .wr_en(sig_we), .wr_addr(ADDR_W'(sig_cnt_ff)), .wr_data(sample_red),
      .rd_addr(sk_raddr), .rd_data(sig_rd));

   nlc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ker_ram (
      .clock(clock), .wr_en(ker_we), .wr_addr(ADDR_W'(ker_cnt_ff)), .wr_data(sample_red),
      .rd_addr(sk_raddr), .rd_data(ker_rd));

   // Work memory A also holds the final products that reads return.
   nlc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_work_a (
      .clock(clock), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(a_wdata),
      .rd_addr(a_raddr), .rd_data(a_rd));

   nlc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_work_b (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(b_raddr), .rd_data(b_rd));

   nlc_modmul u_modmul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .result(mres));

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign act        = action_type'(req_tuser);
   assign req_sample = req_tdata[15:0];
   assign req_index  = req_tdata[26:16];
   assign sample_red = (17'(req_sample) >= 17'(MODULUS)) ?
                       16'(17'(req_sample) - 17'(MODULUS)) : req_sample;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, LEN_W'(valid_ff), rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Transform geometry: butterfly idx splits around the stage's half bit.
   always_comb begin
      n_full    = (ADDR_W + 1)'(1) << log_n_ff;
      n_mask    = ADDR_W'(n_full - (ADDR_W + 1)'(1));
      half_last = n_mask >> 1;
      hbit      = ADDR_W'(1) << (stage_ff - LOG_W'(1));
      hmask     = hbit - ADDR_W'(1);
      ia        = ((idx_ff & ~hmask) << 1) | (idx_ff & hmask);
      ib        = ia | hbit;
      idx_last  = (idx_ff == n_mask);
      bf_last   = (idx_ff == half_last);
      work_rd   = mem_b_ff ? b_rd : a_rd;
      wl        = (state_ff == ST_FWD) ? FWD_ROOT[stage_ff] : INV_ROOT[stage_ff];
      longer    = (sig_cnt_ff > ker_cnt_ff) ? sig_cnt_ff : ker_cnt_ff;
      new_log   = LOG_W'(2);
      for (int i = 0; i < CNT_W; i++) begin
         if (longer[i]) new_log = LOG_W'(i + 2);
      end
   end

   // Memory ports and multiplier operands.
   always_comb begin
      sig_we   = req_fire && (act == ACT_LOAD_SIG) && (sig_cnt_ff != CNT_W'(MAX_COUNT));
      ker_we   = req_fire && (act == ACT_LOAD_KER) && (ker_cnt_ff != CNT_W'(MAX_COUNT));
      sk_raddr = idx_ff;
      a_we     = 1'b0;
      b_we     = 1'b0;
      a_waddr  = idx_ff;
      b_waddr  = idx_ff;
      a_wdata  = mres;
      b_wdata  = mres;
      a_raddr  = idx_ff;
      b_raddr  = idx_ff;
      mul_a    = a_rd;
      mul_b    = b_rd;
      bf_wr    = (us_ff == US_WR_A) ?
                 add_mod(u_ff, (state_ff == ST_FWD) ? t_ff : mres) :
                 ((state_ff == ST_FWD) ? res_ff : sub_mod(u_ff, res_ff));
      case (state_ff)
         ST_IDLE: begin
            a_raddr = ADDR_W'(req_index);
         end
         ST_COPY: begin
            a_we    = (us_ff == US_E_MUL);
            b_we    = (us_ff == US_E_MUL);
            a_wdata = (idx_ff < ADDR_W'(sig_cnt_ff)) ? sig_rd : 16'd0;
            b_wdata = (idx_ff < ADDR_W'(ker_cnt_ff)) ? ker_rd : 16'd0;
         end
         ST_FWD, ST_INV: begin
            a_raddr = (us_ff == US_RD_A) ? ia : ib;
            b_raddr = a_raddr;
            a_waddr = (us_ff == US_WR_A) ? ia : ib;
            b_waddr = a_waddr;
            a_wdata = bf_wr;
            b_wdata = bf_wr;
            a_we    = !mem_b_ff && ((us_ff == US_WR_A) || (us_ff == US_WR_B));
            b_we    = mem_b_ff && ((us_ff == US_WR_A) || (us_ff == US_WR_B));
            if (us_ff == US_MUL_X) begin
               mul_a = x_ff;
               mul_b = wl;
            end else begin
               mul_a = (state_ff == ST_FWD) ? sub_mod(u_ff, t_ff) : t_ff;
               mul_b = x_ff;
            end
         end
         ST_POINT: begin
            a_we = (us_ff == US_E_WR);
         end
         ST_SCALE: begin
            a_we  = (us_ff == US_E_WR);
            mul_b = N_INV[log_n_ff];
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      sig_cnt_in    = sig_cnt_ff;
      ker_cnt_in    = ker_cnt_ff;
      valid_in      = valid_ff;
      log_n_in      = log_n_ff;
      stage_in      = stage_ff;
      idx_in        = idx_ff;
      us_in         = us_ff + 4'd1;
      mem_b_in      = mem_b_ff;
      x_in          = x_ff;
      u_in          = u_ff;
      t_in          = t_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            us_in = 4'd0;
            if (req_fire) begin
               rsp_value_in  = 16'd0;
               rsp_status_in = STAT_OK;
               rsp_valid_in  = 1'b1;
               case (act)
                  ACT_CLEAR: begin
                     sig_cnt_in = '0;
                     ker_cnt_in = '0;
                     valid_in   = '0;
                  end
                  ACT_LOAD_SIG: begin
                     if (sig_we) sig_cnt_in = sig_cnt_ff + CNT_W'(1);
                     else        rsp_status_in = STAT_FULL;
                  end
                  ACT_LOAD_KER: begin
                     if (ker_we) ker_cnt_in = ker_cnt_ff + CNT_W'(1);
                     else        rsp_status_in = STAT_FULL;
                  end
                  ACT_COMPUTE: begin
                     if (sig_cnt_ff == '0 || ker_cnt_ff == '0) begin
                        valid_in      = '0;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        log_n_in     = new_log;
                        idx_in       = '0;
                        state_in     = ST_COPY;
                     end
                  end
                  ACT_READ: begin
                     if (32'(req_index) >= 32'(valid_ff)) begin
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_value_in = a_rd;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            if (us_ff == US_E_MUL) begin
               us_in  = 4'd0;
               idx_in = idx_ff + ADDR_W'(1);
               if (idx_last) begin
                  idx_in   = '0;
                  stage_in = log_n_ff;
                  mem_b_in = 1'b0;
                  state_in = ST_FWD;
               end
            end
         end
         ST_FWD, ST_INV: begin
            case (us_ff)
               US_RD_A:  if ((idx_ff & hmask) == '0) x_in = 16'd1;
               US_GET_U: u_in = work_rd;
               US_GET_T: t_in = work_rd;
               US_WR_A:  res_in = mres;
               US_WR_B: begin
                  x_in  = mres;
                  us_in = 4'd0;
                  idx_in = idx_ff + ADDR_W'(1);
                  if (bf_last) begin
                     idx_in = '0;
                     if (state_ff == ST_FWD) begin
                        if (stage_ff != LOG_W'(1)) begin
                           stage_in = stage_ff - LOG_W'(1);
                        end else if (!mem_b_ff) begin
                           mem_b_in = 1'b1;
                           stage_in = log_n_ff;
                        end else begin
                           mem_b_in = 1'b0;
                           state_in = ST_POINT;
                        end
                     end else if (stage_ff == log_n_ff) begin
                        state_in = ST_SCALE;
                     end else begin
                        stage_in = stage_ff + LOG_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_POINT, ST_SCALE: begin
            if (us_ff == US_E_WR) begin
               us_in  = 4'd0;
               idx_in = idx_ff + ADDR_W'(1);
               if (idx_last) begin
                  idx_in = '0;
                  if (state_ff == ST_POINT) begin
                     stage_in = LOG_W'(1);
                     state_in = ST_INV;
                  end else begin
                     valid_in      = ADDR_W'(sig_cnt_ff) + ADDR_W'(ker_cnt_ff) - ADDR_W'(1);
                     rsp_value_in  = 16'd0;
                     rsp_status_in = STAT_OK;
                     rsp_valid_in  = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sig_cnt_ff   <= '0;
         ker_cnt_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         us_ff        <= 4'd0;
      end else begin
         state_ff     <= state_in;
         sig_cnt_ff   <= sig_cnt_in;
         ker_cnt_ff   <= ker_cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         us_ff        <= us_in;
      end
   end

   always_ff @(posedge clock) begin
      log_n_ff      <= log_n_in;
      stage_ff      <= stage_in;
      idx_ff        <= idx_in;
      mem_b_ff      <= mem_b_in;
      x_ff          <= x_in;
      u_ff          <= u_in;
      t_ff          <= t_in;
      res_ff        <= res_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== tb/sv/ntt_linear_convolution_unit_test.sv =====
// Self-checking testbench of the NTT linear convolution unit with its own convolution predictor.
module ntt_linear_convolution_unit_test;
   import nlc_pkg::*;

   // Actions 5 to 7 have no meaning; the block must answer them with status OK and no change.
   localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int QUIET_TAIL  = 150;
   localparam int ITEM_TOTAL  = 1350;
   localparam int KERNEL_FILL = 40;

   typedef struct {
      logic [ACT_W-1:0] action;
      logic [SMP_W-1:0] sample;
      logic [IDX_W-1:0] read_index;
      bit               drain;     // hold the request back until all responses are in
   } conv_request_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   result_length;
      logic [STAT_W-1:0]  status;
   } conv_response_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // sample [15:0], read_index [26:16]
   logic [ACT_W-1:0]      req_tuser;   // action [2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // value [15:0], result_length [26:16]
   logic [STAT_W-1:0]     rsp_tuser;   // status [1:0]

   ntt_linear_convolution_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   conv_request_type  pending_requests[$];
   conv_response_type awaited_responses[$];
   int           error_count;
   int           request_count;
   int           compute_count;
   int           read_hits;
   int           cycle_count;

   // Predictor state: the two loaded sequences, the convolution and the counts.
   logic [15:0]  signal_mem[DEPTH];
   logic [15:0]  kernel_mem[DEPTH];
   logic [15:0]  conv_mem[DEPTH];
   int unsigned  signal_len;
   int unsigned  kernel_len;
   int unsigned  conv_len;
   int unsigned  ntt_buf[DEPTH];
   int unsigned  spec_signal[DEPTH];

   function automatic int unsigned mod_mul(input int unsigned a, input int unsigned b);
      longint unsigned p;
      p = longint'(a) * longint'(b);
      return int'(p % MODULUS);
   endfunction

   function automatic int unsigned mod_pow(input int unsigned b, input int unsigned e);
      int unsigned r;
      int unsigned bb;
      r = 1;
      bb = b % MODULUS;
      while (e > 0) begin
         if (e[0]) r = mod_mul(r, bb);
         bb = mod_mul(bb, bb);
         e = e >> 1;
      end
      return r;
   endfunction

   // In-place iterative transform of ntt_buf over n points with twiddle w.
   function automatic void ntt_in_place(input int unsigned n, input int unsigned w);
      int unsigned j;
      int unsigned bitv;
      int unsigned t;
      int unsigned half;
      int unsigned wl;
      int unsigned x;
      int unsigned u;
      j = 0;
      for (int unsigned i = 1; i < n; i++) begin
         bitv = n >> 1;
         while ((j & bitv) != 0) begin
            j = j ^ bitv;
            bitv = bitv >> 1;
         end
         j = j ^ bitv;
         if (i < j) begin
            t = ntt_buf[i];
            ntt_buf[i] = ntt_buf[j];
            ntt_buf[j] = t;
         end
      end
      for (int unsigned len = 2; len <= n; len = len << 1) begin
         half = len >> 1;
         wl = mod_pow(w, n / len);
         for (int unsigned i = 0; i < n; i += len) begin
            x = 1;
            for (int unsigned k = 0; k < half; k++) begin
               u = ntt_buf[i + k];
               t = mod_mul(ntt_buf[i + k + half], x);
               ntt_buf[i + k] = (u + t) % MODULUS;
               ntt_buf[i + k + half] = (u + MODULUS - t) % MODULUS;
               x = mod_mul(x, wl);
            end
         end
      end
   endfunction

   // Convolution of the loaded sequences; returns the compute status.
   function automatic logic [STAT_W-1:0] convolve_sequences();
      int unsigned longer;
      int unsigned p;
      int unsigned n;
      int unsigned w;
      int unsigned scale;
      if (signal_len == 0 || kernel_len == 0) begin
         conv_len = 0;
         return STAT_EMPTY;
      end
      longer = (signal_len > kernel_len) ? signal_len : kernel_len;
      p = 1;
      while (p <= longer) p = p << 1;
      n = 2 * p;
      w = ROOT;
      // Square the root of order 8192 down to a root of order n.
      for (int unsigned o = ROOT_ORDER; o / 2 >= n; o = o / 2) w = mod_mul(w, w);
      for (int unsigned i = 0; i < n; i++) ntt_buf[i] = (i < signal_len) ? signal_mem[i] : 0;
      ntt_in_place(n, w);
      for (int unsigned i = 0; i < n; i++) spec_signal[i] = ntt_buf[i];
      for (int unsigned i = 0; i < n; i++) ntt_buf[i] = (i < kernel_len) ? kernel_mem[i] : 0;
      ntt_in_place(n, w);
      for (int unsigned i = 0; i < n; i++) ntt_buf[i] = mod_mul(ntt_buf[i], spec_signal[i]);
      ntt_in_place(n, mod_pow(w, n - 1));
      scale = mod_pow(n, MODULUS - 2);
      for (int unsigned i = 0; i < n; i++) conv_mem[i] = 16'(mod_mul(ntt_buf[i], scale));
      conv_len = signal_len + kernel_len - 1;
      return STAT_OK;
   endfunction

   // Advances the predictor by one request and returns the response it must cause.
   function automatic conv_response_type predict_response(input conv_request_type rq);
      conv_response_type rs;
      rs.value = '0;
      rs.status = STAT_OK;
      case (rq.action)
         ACT_CLEAR: begin
            for (int i = 0; i < DEPTH; i++) begin
               signal_mem[i] = '0;
               kernel_mem[i] = '0;
               conv_mem[i] = '0;
            end
            signal_len = 0;
            kernel_len = 0;
            conv_len = 0;
         end
         ACT_LOAD_SIG: begin
            if (signal_len >= MAX_COUNT) rs.status = STAT_FULL;
            else begin
               signal_mem[signal_len] = 16'(rq.sample % MODULUS);
               signal_len++;
            end
         end
         ACT_LOAD_KER: begin
            if (kernel_len >= MAX_COUNT) rs.status = STAT_FULL;
            else begin
               kernel_mem[kernel_len] = 16'(rq.sample % MODULUS);
               kernel_len++;
            end
         end
         ACT_COMPUTE: begin
            rs.status = convolve_sequences();
            compute_count++;
         end
         ACT_READ: begin
            if (rq.read_index >= conv_len) rs.status = STAT_RANGE;
            else begin
               rs.value = conv_mem[rq.read_index];
               read_hits++;
            end
         end
         default: ;
      endcase
      rs.result_length = LEN_W'(conv_len);
      return rs;
   endfunction

   // Noise requests: any action including the spare ones, with fully random fields.
   function automatic logic [ACT_W-1:0] random_action();
      return ACT_W'($urandom_range(ACT_CLEAR, ACT_SPARE_LAST));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic push_request(input logic [ACT_W-1:0] act, input int smp, input int idx,
                               input bit drain);
      conv_request_type rq;
      rq.action = act;
      rq.sample = SMP_W'(smp);
      rq.read_index = IDX_W'(idx);
      rq.drain = drain;
      pending_requests.push_back(rq);
   endtask

   // One well-formed run: clear, interleaved loads, compute, reads mostly in range.
   task automatic push_convolution_run(input int m, input int k, input int reads);
      int ms;
      int ks;
      push_request(ACT_CLEAR, $urandom, $urandom, 1'b0);
      ms = 0;
      ks = 0;
      while (ms < m || ks < k) begin
         if (ks >= k || (ms < m && $urandom_range(0, 1) == 0)) begin
            push_request(ACT_LOAD_SIG, $urandom, $urandom, 1'b0);
            ms++;
         end else begin
            push_request(ACT_LOAD_KER, $urandom, $urandom, 1'b0);
            ks++;
         end
      end
      push_request(ACT_COMPUTE, $urandom, $urandom, $urandom_range(0, 19) == 0);
      for (int r = 0; r < reads; r++) begin
         if ($urandom_range(0, 5) == 0) push_request(ACT_READ, $urandom, $urandom, 1'b0);
         else push_request(ACT_READ, $urandom, $urandom_range(0, m + k - 1), 1'b0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Driver: sends at a falling edge after the last request was taken, if no gap or drain.
   conv_request_type current_request;
   bit          req_taken;
   int          send_gap;
   int          recv_gap;

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (send_gap > 0 && pending_requests.size() > QUIET_TAIL) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0 &&
                      !(pending_requests[0].drain && awaited_responses.size() > 0)) begin
            current_request = pending_requests.pop_front();
            req_tuser  <= current_request.action;
            req_tdata  <= {5'b0, current_request.read_index, current_request.sample};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 13);
            else send_gap <= 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side stalls in bursts too, except near the end of the run.
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap > 0 && pending_requests.size() > QUIET_TAIL) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 13);
            else recv_gap <= 0;
         end
      end
   end

   // Every accepted request adds its predicted response to the queue.
   always @(posedge clock) begin
      conv_response_type rs;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         rs = predict_response(current_request);
         awaited_responses.push_back(rs);
         request_count++;
      end
   end

   // Monitor: each accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      conv_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("unexpected response, value", int'(rsp_tdata[15:0]), 0);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_tdata[15:0] !== want.value)
               report_mismatch("value", int'(rsp_tdata[15:0]), int'(want.value));
            if (rsp_tdata[26:16] !== want.result_length)
               report_mismatch("result_length", int'(rsp_tdata[26:16]),
                               int'(want.result_length));
            if (rsp_tuser !== want.status)
               report_mismatch("status", int'(rsp_tuser), int'(want.status));
         end
      end
   end

   initial begin
      int m;
      int k;
      error_count = 0;
      request_count = 0;
      compute_count = 0;
      read_hits = 0;
      cycle_count = 0;
      send_gap = 0;
      recv_gap = 0;
      req_taken = 1'b0;
      signal_len = 0;
      kernel_len = 0;
      conv_len = 0;
      for (int i = 0; i < DEPTH; i++) begin
         signal_mem[i] = '0;
         kernel_mem[i] = '0;
         conv_mem[i] = '0;
      end
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_CLEAR;
      rsp_tready = 1'b0;

      // Directed part: reads before any compute, empty computes, spare actions,
      // sample extremes around the modulus, loads after compute.
      push_request(ACT_READ, 0, 0, 1'b0);
      push_request(ACT_COMPUTE, 0, 0, 1'b0);
      push_request(ACT_SPARE_FIRST, 16'hffff, 11'h7ff, 1'b0);
      push_request(ACT_SPARE_LAST, 16'hffff, 11'h7ff, 1'b0);
      push_request(ACT_LOAD_SIG, 16'hffff, 0, 1'b0);
      push_request(ACT_LOAD_SIG, 0, 0, 1'b0);
      push_request(ACT_LOAD_SIG, MODULUS, 0, 1'b0);
      push_request(ACT_LOAD_SIG, MODULUS - 1, 0, 1'b0);
      push_request(ACT_COMPUTE, 0, 0, 1'b0);           // kernel still empty
      push_request(ACT_LOAD_KER, 1, 0, 1'b0);
      push_request(ACT_LOAD_KER, 16'hffff, 11'h7ff, 1'b0);
      push_request(ACT_COMPUTE, 0, 0, 1'b1);
      push_request(ACT_READ, 0, 0, 1'b0);
      push_request(ACT_READ, 0, 3, 1'b0);
      push_request(ACT_READ, 0, 4, 1'b0);
      push_request(ACT_READ, 0, 5, 1'b0);
      push_request(ACT_READ, 16'hffff, 11'h7ff, 1'b0);
      push_request(ACT_LOAD_KER, 12345, 0, 1'b0);      // old results must stay readable
      push_request(ACT_READ, 0, 2, 1'b0);
      push_request(ACT_CLEAR, 16'hffff, 11'h7ff, 1'b0);
      push_request(ACT_READ, 0, 0, 1'b0);
      push_request(ACT_LOAD_SIG, 7, 0, 1'b0);
      push_request(ACT_COMPUTE, 0, 0, 1'b0);           // signal only: empty kernel
      push_request(ACT_LOAD_KER, 9, 0, 1'b0);
      push_request(ACT_COMPUTE, 0, 0, 1'b0);
      push_request(ACT_READ, 0, 0, 1'b0);

      // The signal filled past capacity, a short kernel, then the largest transform.
      push_request(ACT_CLEAR, 0, 0, 1'b0);
      for (int i = 0; i <= MAX_COUNT; i++) push_request(ACT_LOAD_SIG, $urandom, 0, 1'b0);
      for (int i = 0; i < KERNEL_FILL; i++) push_request(ACT_LOAD_KER, $urandom, 0, 1'b0);
      push_request(ACT_COMPUTE, 0, 0, 1'b1);
      push_request(ACT_READ, 0, 0, 1'b0);
      push_request(ACT_READ, 0, MAX_COUNT + KERNEL_FILL - 2, 1'b0);
      push_request(ACT_READ, 0, MAX_COUNT + KERNEL_FILL - 1, 1'b0);
      for (int i = 0; i < 8; i++) push_request(ACT_READ, 0, $urandom_range(0, 2047), 1'b0);

      // Random part: mostly well-formed runs of small sizes, the rest noise.
      while (pending_requests.size() < ITEM_TOTAL) begin
         if ($urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               m = $urandom_range(1, 60);
               k = $urandom_range(1, 60);
            end else begin
               m = $urandom_range(1, 12);
               k = $urandom_range(1, 12);
            end
            push_convolution_run(m, k, $urandom_range(3, 12));
         end else begin
            for (int i = 0; i < 4; i++) begin
               push_request(random_action(), $urandom, $urandom, 1'b0);
            end
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() > 0 || req_tvalid) @(posedge clock);
      while (awaited_responses.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d requests: %0d computes, %0d in-range reads, full and empty cases",
               request_count, compute_count, read_hits);
      $display("largest transform of 2048 points, stalls on both sides, %0d mismatches",
               error_count);
      if (error_count == 0 && awaited_responses.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
